// ----- design/zmn_pkg.sv -----
`default_nettype none
package zmn_pkg;

    localparam int BLOCK_SIZE_DEF = 8;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 22;
    localparam int ADJ_W    = 17;
    localparam int SQ_W     = 37;
    localparam int ROOT_W   = 19;
    localparam int QUO_W    = 32;
    localparam int DVS_W    = 19;
    localparam int FRAC_W   = 14;

    typedef struct packed {
        logic               start;
        logic [QUO_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ----- design/zmn_div.sv -----
`default_nettype none
module zmn_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  zmn_pkg::t_div_req  i_req,
    output zmn_pkg::t_div_rsp  o_rsp
);
    import zmn_pkg::*;

    localparam int STEPS = QUO_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DVS_W:0]     r_rem, n_rem;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [DVS_W-1:0]   r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int i = 0; i < 2; i++) begin
            n_rem = {n_rem[DVS_W-1:0], n_quo[QUO_W-1]};
            n_quo = {n_quo[QUO_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_div}) begin
                n_rem    = n_rem - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

// ----- design/zmn_sqrt.sv -----
`default_nettype none
module zmn_sqrt (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [zmn_pkg::SQ_W-1:0]     i_radicand,
    output logic                        o_done,
    output logic [zmn_pkg::ROOT_W-1:0]  o_root
);
    import zmn_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [REM_W-1:0]   n_rem;
    logic [REM_W-1:0]   trial;

    always_comb begin
        n_rem = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial = REM_W'({r_root, 2'b01});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= RAD_W'(i_radicand);
            end else if (r_busy) begin
                r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                if (n_rem >= trial) begin
                    r_rem  <= n_rem - trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ----- design/zero_mean_unit_norm_vector.sv -----
`default_nettype none
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------------
// input    | i_valid / o_stall   | i_sample_value
// output   | o_valid / i_stall   | o_norm_value, o_last_of_block, o_mean_removed
//
// Load accepts one request per cycle, BLOCK_SIZE^2 requests per vector.
// Then: the mean (reciprocal multiply), a square pass, the root, and per
// element a memory read plus the 2-bit-per-cycle divider, skipped if all zero.
// Synchronous active-low reset; the element memory needs no clearing.
// o_stall is high outside the load phase; a full output register waits on i_stall.
module zero_mean_unit_norm_vector #(
    parameter int BLOCK_SIZE = zmn_pkg::BLOCK_SIZE_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire signed [zmn_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic signed [zmn_pkg::SAMPLE_W-1:0] o_norm_value,
    output logic                             o_last_of_block,
    output logic                             o_mean_removed
);
    import zmn_pkg::*;

    localparam int N      = BLOCK_SIZE * BLOCK_SIZE;
    localparam int AW     = $clog2(N);
    localparam int CW     = AW + 1;
    localparam int PW     = 2 * ADJ_W;
    localparam int MEAN_K = SUM_W + $clog2(N);
    localparam int RCP_W  = SUM_W + 2;
    localparam int MP_W   = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] MEAN_RCP = RCP_W'(((1 << MEAN_K) + N - 1) / N);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_MEAN0 = 4'd1;
    localparam logic [3:0] S_MEAN1 = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_ROOT0 = 4'd4;
    localparam logic [3:0] S_ROOT1 = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_DIV0  = 4'd7;
    localparam logic [3:0] S_DIV1  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]                 r_state;
    logic [CW-1:0]              r_idx;
    logic signed [SUM_W-1:0]    r_sum;
    logic                       r_nonneg;
    logic                       r_neg;
    logic                       r_mixed;
    logic signed [ADJ_W-1:0]    r_mean;
    logic [MP_W-1:0]            r_mprod;
    logic [SQ_W-1:0]            r_sq;
    logic [ROOT_W-1:0]          r_root;
    logic                       r_rd_v;
    logic                       r_prod_v;
    logic [PW-1:0]              r_prod;
    logic signed [ADJ_W-1:0]    r_v;
    logic signed [SAMPLE_W-1:0] r_res;

    logic [SAMPLE_W-1:0]        mem [N];
    logic [SAMPLE_W-1:0]        r_rdata;
    logic [AW-1:0]              rd_addr;

    logic                       in_acc;
    logic                       out_free;
    logic signed [ADJ_W-1:0]    adj;
    logic [ADJ_W-1:0]           adj_mag;
    logic [SUM_W-1:0]           sum_mag;
    logic [ADJ_W-1:0]           mean_mag;
    logic [QUO_W-1:0]           q;
    logic signed [ADJ_W-1:0]    res_w;

    t_div_req                   div_req;
    t_div_rsp                   div_rsp;
    logic                       sq_start;
    logic                       sq_done;
    logic [ROOT_W-1:0]          sq_root;

    assign o_stall  = (r_state != S_LOAD);
    assign in_acc   = i_valid && (r_state == S_LOAD);
    assign out_free = !o_valid || !i_stall;
    assign rd_addr  = r_idx[AW-1:0];
    assign mean_mag = r_mprod[MEAN_K +: ADJ_W];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[rd_addr] <= i_sample_value;
        end
        r_rdata <= mem[rd_addr];
    end

    always_comb begin
        adj = ADJ_W'($signed(r_rdata));
        if (r_mixed) begin
            adj = adj - r_mean;
        end
        adj_mag = adj[ADJ_W-1] ? ADJ_W'(-adj) : adj;
        sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
        q = div_rsp.quotient;
        if (q > QUO_W'(32768)) begin
            q = QUO_W'(32768);
        end
        res_w = r_v[ADJ_W-1] ? -$signed(ADJ_W'(q)) : $signed(ADJ_W'(q));
        if (res_w > ADJ_W'(32767)) begin
            res_w = ADJ_W'(32767);
        end
    end

    always_comb begin
        div_req.start    = (r_state == S_DIV0) && (r_sq != '0);
        div_req.dividend = QUO_W'({adj_mag, FRAC_W'(0)});
        div_req.divisor  = DVS_W'(r_root);
    end

    assign sq_start = (r_state == S_ROOT0);

    zmn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    zmn_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_sq),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_idx    <= '0;
            r_sum    <= '0;
            r_nonneg <= 1'b0;
            r_neg    <= 1'b0;
            r_mixed  <= 1'b0;
            r_sq     <= '0;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (o_valid && !i_stall && (r_state != S_OUT)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_sum <= r_sum + SUM_W'(i_sample_value);
                        if (i_sample_value[SAMPLE_W-1]) begin
                            r_neg <= 1'b1;
                        end else begin
                            r_nonneg <= 1'b1;
                        end
                        if (r_idx == CW'(N - 1)) begin
                            r_idx   <= '0;
                            r_state <= S_MEAN0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_MEAN0: begin
                    r_mprod <= MP_W'(sum_mag) * MP_W'(MEAN_RCP);
                    r_state <= S_MEAN1;
                end
                S_MEAN1: begin
                    r_mean   <= r_sum[SUM_W-1] ? -$signed(mean_mag) : $signed(mean_mag);
                    r_mixed  <= r_nonneg && r_neg;
                    r_sum    <= '0;
                    r_nonneg <= 1'b0;
                    r_neg    <= 1'b0;
                    r_sq     <= '0;
                    r_idx    <= '0;
                    r_rd_v   <= 1'b0;
                    r_prod_v <= 1'b0;
                    r_state  <= S_SQ;
                end
                S_SQ: begin
                    if (r_idx != CW'(N)) begin
                        r_idx  <= r_idx + 1'b1;
                        r_rd_v <= 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    r_prod   <= PW'(adj) * PW'(adj);
                    r_prod_v <= r_rd_v;
                    if (r_prod_v) begin
                        r_sq <= r_sq + SQ_W'(r_prod);
                    end
                    if (r_idx == CW'(N) && !r_rd_v && !r_prod_v) begin
                        r_state <= S_ROOT0;
                    end
                end
                S_ROOT0: begin
                    r_state <= S_ROOT1;
                end
                S_ROOT1: begin
                    if (sq_done) begin
                        r_root  <= sq_root;
                        r_idx   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_DIV0;
                end
                S_DIV0: begin
                    r_v <= adj;
                    if (r_sq == '0) begin
                        r_res   <= SAMPLE_W'(adj);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        r_res   <= SAMPLE_W'(res_w);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        o_valid         <= 1'b1;
                        o_norm_value    <= r_res;
                        o_last_of_block <= (r_idx == CW'(N - 1));
                        o_mean_removed  <= r_mixed;
                        if (r_idx == CW'(N - 1)) begin
                            r_idx   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/zero_mean_unit_norm_vector_test.sv -----
`default_nettype none
module zero_mean_unit_norm_vector_test;

    localparam int BSIZE = zmn_pkg::BLOCK_SIZE_DEF;
    localparam int NELEM = BSIZE * BSIZE;
    localparam int NVEC  = 1;

    typedef struct {
        logic signed [15:0] value;
        logic               last;
        logic               mean_rm;
    } t_norm_out;

    class norm_scoreboard;
        logic signed [15:0] samples[NELEM];
        int                 n_loaded;
        t_norm_out          pending[$];
        int                 n_errors;

        function new();
            n_loaded = 0;
            n_errors = 0;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v    = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        function void note_request(logic signed [15:0] s);
            longint          sum;
            longint          mean;
            longint          adj[NELEM];
            longint unsigned sq;
            longint unsigned root;
            longint unsigned q;
            longint          res;
            bit              has_pos;
            bit              has_neg;
            bit              mixed;
            t_norm_out       o;
            samples[n_loaded] = s;
            n_loaded++;
            if (n_loaded < NELEM) return;
            n_loaded = 0;
            sum = 0;
            has_pos = 0;
            has_neg = 0;
            foreach (samples[k]) begin
                sum += samples[k];
                if (samples[k] < 0) has_neg = 1; else has_pos = 1;
            end
            mixed = has_pos && has_neg;
            mean = sum / NELEM;
            sq = 0;
            foreach (samples[k]) begin
                adj[k] = mixed ? samples[k] - mean : longint'(samples[k]);
                sq += longint'(adj[k] * adj[k]);
            end
            sq &= 64'h1F_FFFF_FFFF;
            root = isqrt(sq);
            for (int k = 0; k < NELEM; k++) begin
                res = adj[k];
                if (sq != 0 && root != 0) begin
                    q = ((adj[k] < 0) ? -adj[k] : adj[k]) * 16384 / root;
                    if (q > 32768) q = 32768;
                    res = (adj[k] < 0) ? -longint'(q) : longint'(q);
                    if (res > 32767) res = 32767;
                end
                o.value   = res[15:0];
                o.last    = (k == NELEM - 1);
                o.mean_rm = mixed;
                pending.insert(pending.size(), o);
            end
        endfunction

        function void check_result(logic signed [15:0] v, logic l, logic m);
            t_norm_out e;
            if (pending.size() == 0) begin
                $error("unexpected result norm_value=%0d", v);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            if (v !== e.value) begin
                $error("norm_value expected %0d actual %0d", e.value, v);
                n_errors++;
            end
            if (l !== e.last) begin
                $error("last_of_block expected %0b actual %0b", e.last, l);
                n_errors++;
            end
            if (m !== e.mean_rm) begin
                $error("mean_removed expected %0b actual %0b", e.mean_rm, m);
                n_errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_sample_value;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_norm_value;
    logic               o_last_of_block;
    logic               o_mean_removed;

    norm_scoreboard sb;
    bit             quiet;

    zero_mean_unit_norm_vector dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_norm_value   (o_norm_value),
        .o_last_of_block(o_last_of_block),
        .o_mean_removed (o_mean_removed)
    );

    initial i_clk = 0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_norm_value, o_last_of_block, o_mean_removed);
        end
        if (i_rst_n) i_stall <= (!quiet && $urandom_range(99) < 6);
    end

    task automatic send_request(logic signed [15:0] s);
        while (!quiet && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_value <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(s);
    endtask

    function automatic logic signed [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom_range(32768) - 16384);
            1: return 16'($urandom_range(16384));
            2: return -$signed({1'b0, 15'($urandom_range(16384))});
            3: return 16'($urandom_range(40) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int mode;
        sb             = new();
        quiet          = 0;
        i_rst_n        = 0;
        i_valid        = 0;
        i_stall        = 0;
        i_sample_value = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // all zero, then extreme mixed with no idling
        for (int k = 0; k < NELEM; k++) send_request(16'sd0);
        quiet = 1;
        for (int k = 0; k < NELEM; k++)
            send_request((k % 2) ? 16'sh7FFF : 16'sh8000);
        quiet = 0;
        for (int v = 0; v < NVEC; v++) begin
            mode = $urandom_range(4);
            for (int k = 0; k < NELEM; k++) send_request(rand_sample(mode));
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
design/zmn_pkg.sv
design/zmn_div.sv
design/zmn_sqrt.sv
design/zero_mean_unit_norm_vector.sv
tb/sv/zero_mean_unit_norm_vector_test.sv
